/* rtl/kctr_pkg.sv */
// kctr_pkg: constants and types for the key climb trace row block
// field prime, chunk layout and word widths; no dependencies
package kctr_pkg;

	localparam int WordW    = 64;
	localparam int NumWords = 4;
	localparam int ChunkW   = 18;
	localparam int LastW    = 10;
	localparam int Rows     = 4;
	localparam int LevelW   = 8;
	localparam int CodeW    = 2;
	localparam int InDataW  = 272;
	localparam int OutDataW = 352;
	localparam int OutUserW = 5;

	localparam logic [WordW-1:0] GlPrime = 64'hFFFF_FFFF_0000_0001;

	// row codes
	localparam logic [1:0] RowResult = 2'd2;
	localparam logic [1:0] RowLast   = 2'd3;

	// prime chunks and chunk masks, row 0 first
	localparam logic [ChunkW-1:0] PrimeChunk [Rows] = '{
		18'h00001, 18'h3C000, 18'h3FFFF, 18'h003FF
	};
	localparam logic [ChunkW-1:0] ChunkMask [Rows] = '{
		18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h003FF
	};

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumWords-1:0] key_t;
	typedef logic [CodeW-1:0] code_t;
	typedef code_t [Rows-1:0] codes_t;

	// common item fields carried down the pipeline
	typedef struct packed {
		key_t              key;
		logic [LevelW-1:0] level;
		logic              bit_in;
	} item_t;

endpackage

/* rtl/key_climb_trace_rows.sv */
// key_climb_trace_rows: climbs one key word and emits four trace rows per word
// depends on kctr_pkg
//
// Each input word carries a four-word key, a tree level and one bit; the word picked
// by the level's low two bits is climbed to 2*w+bit mod p and four output words (trace
// rows) follow, one per cycle while m_tready is high, the last marked by m_tlast. An
// input word passes through the pipeline stages (reduce, select and double, add bit and
// carry chain) into the row sequencer at the output, which holds one item while its four
// rows go out; the next item is accepted and worked on while rows of the previous one
// are still going out, and if it is waiting in stage 3 the last row is followed by the
// next item's first row in the following cycle.
module key_climb_trace_rows (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// key_word0, key_word1, key_word2, key_word3, tree_level, in_bit, zero fill
	input  logic [kctr_pkg::InDataW-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_word0..out_word3, level_echo, chunk_value, partial_key, bit_echo,
	// carry_lt, zero fill
	output logic [kctr_pkg::OutDataW-1:0] m_tdata,
	// word_select, result_row
	output logic [kctr_pkg::OutUserW-1:0] m_tuser,
	output logic                         m_tlast
);
	import kctr_pkg::*;

	// stage valids and stall chain
	logic v_s1, v_s2, v_s3, ov_q;
	logic rdy1, rdy2, rdy3, load_out, row_take;
	logic [1:0] row_q;

	item_t item_in, item_s1, item_s2, item_s3;
	word_t word_s2, dbl_s2, word_s3, climb_s3;
	codes_t codes_s3;

	item_t  item_q;
	word_t  word_q, climb_q;
	codes_t codes_q;

	assign row_take = ov_q && m_tready;
	assign load_out = v_s3 && (!ov_q || (row_take && row_q == RowLast));
	assign rdy3     = !v_s3 || load_out;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// stage 1: unpack and reduce each word below p
	always_comb begin
		for (int k = 0; k < NumWords; k++) begin
			item_in.key[k] = (s_tdata[k*WordW +: WordW] >= GlPrime) ?
				s_tdata[k*WordW +: WordW] - GlPrime : s_tdata[k*WordW +: WordW];
		end
		item_in.level  = s_tdata[NumWords*WordW +: LevelW];
		item_in.bit_in = s_tdata[NumWords*WordW + LevelW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	// stage 2: select word and double it mod p
	logic [WordW:0] dbl_sum;
	word_t          sel_word;

	always_comb begin
		sel_word = item_s1.key[item_s1.level[1:0]];
		dbl_sum  = {sel_word, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			item_s2 <= item_s1;
			word_s2 <= sel_word;
			dbl_s2  <= (dbl_sum >= {1'b0, GlPrime}) ?
				WordW'(dbl_sum - {1'b0, GlPrime}) : WordW'(dbl_sum);
		end
	end

	// stage 3: add the bit mod p and run the carry / less-than chain
	word_t  climb_c;
	codes_t codes_c;
	logic   carry_c, lt_c;
	logic [ChunkW-1:0] chunk_c, crop_c;
	logic [ChunkW:0]   up_c;

	always_comb begin
		climb_c = dbl_s2 + {{(WordW-1){1'b0}}, item_s2.bit_in};
		if (climb_c == GlPrime) begin
			climb_c = '0;
		end
		carry_c = item_s2.bit_in;
		lt_c    = 1'b0;
		for (int c = 0; c < Rows; c++) begin
			codes_c[c] = {lt_c, carry_c};
			if (c == Rows - 1) begin
				chunk_c = {{(ChunkW-LastW){1'b0}}, word_s2[WordW-1 -: LastW]};
			end else begin
				chunk_c = word_s2[c*ChunkW +: ChunkW];
			end
			up_c    = {chunk_c, carry_c};
			carry_c = (up_c > {1'b0, ChunkMask[c]});
			crop_c  = up_c[ChunkW-1:0] & ChunkMask[c];
			if (crop_c < PrimeChunk[c]) begin
				lt_c = 1'b1;
			end else if (crop_c != PrimeChunk[c]) begin
				lt_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			item_s3  <= item_s2;
			word_s3  <= word_s2;
			climb_s3 <= climb_c;
			codes_s3 <= codes_c;
		end
	end

	// row sequencer: holds one item and steps through its four rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			row_q <= '0;
		end else if (load_out) begin
			ov_q  <= 1'b1;
			row_q <= '0;
		end else if (row_take) begin
			if (row_q == RowLast) begin
				ov_q <= 1'b0;
			end
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			item_q  <= item_s3;
			word_q  <= word_s3;
			climb_q <= climb_s3;
			codes_q <= codes_s3;
		end
	end

	// row fields
	key_t              out_key;
	logic [ChunkW-1:0] row_chunk;
	word_t             row_partial;
	logic [3:0]        row_sel;
	logic              is_last, is_result;

	always_comb begin
		is_last   = (row_q == RowLast);
		is_result = (row_q == RowResult);
		out_key   = item_q.key;
		row_sel   = '0;
		if (is_last) begin
			out_key[item_q.level[1:0]] = climb_q;
			row_sel = 4'(1) << item_q.level[1:0];
		end
		case (row_q)
			2'd0: begin
				row_chunk   = word_q[0 +: ChunkW];
				row_partial = {{(WordW-ChunkW){1'b0}}, word_q[ChunkW-1:0]};
			end
			2'd1: begin
				row_chunk   = word_q[ChunkW +: ChunkW];
				row_partial = {{(WordW-2*ChunkW){1'b0}}, word_q[2*ChunkW-1:0]};
			end
			2'd2: begin
				row_chunk   = word_q[2*ChunkW +: ChunkW];
				row_partial = {{(WordW-3*ChunkW){1'b0}}, word_q[3*ChunkW-1:0]};
			end
			default: begin
				row_chunk   = {{(ChunkW-LastW){1'b0}}, word_q[WordW-1 -: LastW]};
				row_partial = word_q;
			end
		endcase
	end

	assign m_tvalid = ov_q;
	assign m_tlast  = is_last;
	assign m_tuser  = {is_result, row_sel};
	assign m_tdata  = {3'b000, codes_q[row_q], item_q.bit_in, row_partial, row_chunk,
		item_q.level, out_key[3], out_key[2], out_key[1], out_key[0]};

	// rows of one item go out back to back once taken
	a_rows_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("row sequence broken before last row");

	// word select is one-hot on the last row only
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast ? $onehot(m_tuser[3:0]) : (m_tuser[3:0] == 4'd0)))
		else $error("word select not one-hot on last row");

	// climbed word stays canonical
	a_climb_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (climb_q < GlPrime))
		else $error("climbed word not below prime");

	// a waiting item is loaded right after the last row leaves
	a_next_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && v_s3) |=> (m_tvalid && row_q == 2'd0))
		else $error("next item not loaded after last row");

endmodule
